[src/lsc_pkg.sv]
// ----------------------------------------------------------------------------
// Line sensor package
// Shared types, level and decision codes and fixed constants of the line
// sensor calibrate and classify block.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int LEVEL_BITS  = 18;
    localparam int THRESH_BITS = 7;
    localparam int SCALE_BITS  = 7;
    localparam int NUM_CH      = 4;

    localparam logic [SCALE_BITS-1:0]  LEVEL_SCALE     = 7'd100;
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 7'd50;

    localparam int LEVEL_MAX = 131071;
    localparam int LEVEL_MIN = -131072;

    localparam logic [1:0] CH_LEFT_IR     = 2'd0;
    localparam logic [1:0] CH_RIGHT_IR    = 2'd1;
    localparam logic [1:0] CH_LEFT_PHOTO  = 2'd2;
    localparam logic [1:0] CH_RIGHT_PHOTO = 2'd3;

    typedef logic signed [2:0]            decision_t;
    typedef logic signed [LEVEL_BITS-1:0] level_t;

    localparam decision_t DEC_KEEP  = 3'sd0;
    localparam decision_t DEC_LEFT  = -3'sd1;
    localparam decision_t DEC_RIGHT = 3'sd1;
    localparam decision_t DEC_CROSS = 3'sd2;

    typedef struct packed {
        logic   done;
        level_t level;
    } lane_res_t;

endpackage

[src/lsc_lane.sv]
// ----------------------------------------------------------------------------
// Line sensor level lane
// Maps one reading to (x - min) * 100 / (max - min) with a bit-serial
// restoring divider on magnitudes, sign fix, flat-range zero and saturation.
// ----------------------------------------------------------------------------
module lsc_lane #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [SAMPLE_BITS-1:0]  x,
    input  logic [SAMPLE_BITS-1:0]  lo,
    input  logic [SAMPLE_BITS-1:0]  hi,
    output lsc_pkg::lane_res_t      res
);

    localparam int SB = SAMPLE_BITS;
    localparam int QW = SAMPLE_BITS + lsc_pkg::SCALE_BITS;
    localparam int CW = $clog2(QW);
    localparam int EW = (QW + 1 > lsc_pkg::LEVEL_BITS + 1) ? QW + 1
                                                            : lsc_pkg::LEVEL_BITS + 1;
    localparam logic signed [EW-1:0] SAT_HI = EW'(lsc_pkg::LEVEL_MAX);
    localparam logic signed [EW-1:0] SAT_LO = EW'(lsc_pkg::LEVEL_MIN);

    typedef enum logic [2:0] {
        LN_IDLE = 3'b001,
        LN_RUN  = 3'b010,
        LN_FIN  = 3'b100
    } lane_state_t;

    lane_state_t           state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [QW-1:0]         dvd_reg, dvd_next;
    logic [SB-1:0]         rem_reg, rem_next;
    logic [SB-1:0]         den_reg, den_next;
    logic                  neg_reg, neg_next;
    logic                  flat_reg, flat_next;
    logic                  done_reg, done_next;
    lsc_pkg::level_t       level_reg, level_next;

    logic [SB:0]           diff, span, diff_abs, span_abs;
    logic [QW-1:0]         product;
    logic [SB:0]           rem_shift, rem_sub;
    logic                  ge;
    logic signed [EW-1:0]  q_ext, q_sgn;

    always_comb begin
        diff      = {1'b0, x} - {1'b0, lo};
        span      = {1'b0, hi} - {1'b0, lo};
        diff_abs  = diff[SB] ? (~diff + 1'b1) : diff;
        span_abs  = span[SB] ? (~span + 1'b1) : span;
        product   = QW'(diff_abs[SB-1:0]) * QW'(lsc_pkg::LEVEL_SCALE);
        rem_shift = {rem_reg, dvd_reg[QW-1]};
        ge        = rem_shift >= {1'b0, den_reg};
        rem_sub   = rem_shift - {1'b0, den_reg};
        q_ext     = {{(EW-QW){1'b0}}, dvd_reg};
        q_sgn     = neg_reg ? -q_ext : q_ext;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        flat_next  = flat_reg;
        done_next  = 1'b0;
        level_next = level_reg;
        unique case (state_reg)
            LN_IDLE: begin
                if (start) begin
                    dvd_next   = product;
                    rem_next   = '0;
                    den_next   = span_abs[SB-1:0];
                    neg_next   = diff[SB] ^ span[SB];
                    flat_next  = (span == '0);
                    cnt_next   = CW'(QW - 1);
                    state_next = LN_RUN;
                end
            end
            LN_RUN: begin
                dvd_next = {dvd_reg[QW-2:0], ge};
                rem_next = ge ? rem_sub[SB-1:0] : rem_shift[SB-1:0];
                if (cnt_reg == '0) begin
                    state_next = LN_FIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            LN_FIN: begin
                if (flat_reg) begin
                    level_next = '0;
                end else if (q_sgn > SAT_HI) begin
                    level_next = SAT_HI[lsc_pkg::LEVEL_BITS-1:0];
                end else if (q_sgn < SAT_LO) begin
                    level_next = SAT_LO[lsc_pkg::LEVEL_BITS-1:0];
                end else begin
                    level_next = q_sgn[lsc_pkg::LEVEL_BITS-1:0];
                end
                done_next  = 1'b1;
                state_next = LN_IDLE;
            end
            default: begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LN_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg   <= cnt_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        flat_reg  <= flat_next;
        level_reg <= level_next;
    end

    assign res.done  = done_reg;
    assign res.level = level_reg;

endmodule

[src/lsc_merge.sv]
// ----------------------------------------------------------------------------
// Line sensor decision merge
// Combines the left and right lane levels against the threshold into one
// steering decision.
// ----------------------------------------------------------------------------
module lsc_merge (
    input  lsc_pkg::level_t                    left_level,
    input  lsc_pkg::level_t                    right_level,
    input  logic [lsc_pkg::THRESH_BITS-1:0]    threshold,
    output lsc_pkg::decision_t                 decision
);

    lsc_pkg::level_t th;
    logic l_over, l_under, r_over, r_under;

    always_comb begin
        th       = {{(lsc_pkg::LEVEL_BITS - lsc_pkg::THRESH_BITS){1'b0}}, threshold};
        l_over   = left_level > th;
        l_under  = left_level < th;
        r_over   = right_level > th;
        r_under  = right_level < th;
        if (l_over && r_under) begin
            decision = lsc_pkg::DEC_LEFT;
        end else if (r_over && l_under) begin
            decision = lsc_pkg::DEC_RIGHT;
        end else if (l_over && r_over) begin
            decision = lsc_pkg::DEC_CROSS;
        end else begin
            decision = lsc_pkg::DEC_KEEP;
        end
    end

endmodule

[src/line_sensor_calibrate_classify.sv]
// ----------------------------------------------------------------------------
// Line sensor calibrate and classify
// Calibration transfer: the result passes the emit step and the output register.
// Check transfer: the result passes the two bit-serial divider lanes, one quotient bit
// per cycle, working in parallel, then the emit step and the output register; no new
// sample is taken until the block is idle again; a held result delays the next emit.
// Synchronous active-low reset: threshold 50, ranges max 0, min all ones.
// ----------------------------------------------------------------------------
module line_sensor_calibrate_classify #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lsc_pkg::THRESH_BITS-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic                                s_sensor_select,
    input  logic [SAMPLE_BITS-1:0]              s_left_ir_sample,
    input  logic [SAMPLE_BITS-1:0]              s_right_ir_sample,
    input  logic [SAMPLE_BITS-1:0]              s_left_photo_sample,
    input  logic [SAMPLE_BITS-1:0]              s_right_photo_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [2:0]                   m_decision,
    output logic signed [lsc_pkg::LEVEL_BITS-1:0] m_left_level,
    output logic signed [lsc_pkg::LEVEL_BITS-1:0] m_right_level
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    logic [lsc_pkg::THRESH_BITS-1:0]     thresh_reg;
    logic [SAMPLE_BITS-1:0]              ch_min_reg [lsc_pkg::NUM_CH];
    logic [SAMPLE_BITS-1:0]              ch_max_reg [lsc_pkg::NUM_CH];
    logic [SAMPLE_BITS-1:0]              samp [lsc_pkg::NUM_CH];
    logic                                is_cal_reg;
    logic                                m_valid_reg, m_valid_next;
    lsc_pkg::decision_t                  m_decision_reg;
    lsc_pkg::level_t                     m_left_reg, m_right_reg;

    logic                                accept, out_load, lane_start;
    logic [SAMPLE_BITS-1:0]              l_x, l_lo, l_hi, r_x, r_lo, r_hi;
    lsc_pkg::lane_res_t                  lane_l, lane_r;
    lsc_pkg::decision_t                  merged;

    assign samp[lsc_pkg::CH_LEFT_IR]     = s_left_ir_sample;
    assign samp[lsc_pkg::CH_RIGHT_IR]    = s_right_ir_sample;
    assign samp[lsc_pkg::CH_LEFT_PHOTO]  = s_left_photo_sample;
    assign samp[lsc_pkg::CH_RIGHT_PHOTO] = s_right_photo_sample;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign lane_start = accept && s_cmd;
    assign out_load   = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        if (s_sensor_select) begin
            l_x  = samp[lsc_pkg::CH_LEFT_IR];
            l_lo = ch_min_reg[lsc_pkg::CH_LEFT_IR];
            l_hi = ch_max_reg[lsc_pkg::CH_LEFT_IR];
            r_x  = samp[lsc_pkg::CH_RIGHT_IR];
            r_lo = ch_min_reg[lsc_pkg::CH_RIGHT_IR];
            r_hi = ch_max_reg[lsc_pkg::CH_RIGHT_IR];
        end else begin
            l_x  = samp[lsc_pkg::CH_LEFT_PHOTO];
            l_lo = ch_min_reg[lsc_pkg::CH_LEFT_PHOTO];
            l_hi = ch_max_reg[lsc_pkg::CH_LEFT_PHOTO];
            r_x  = samp[lsc_pkg::CH_RIGHT_PHOTO];
            r_lo = ch_min_reg[lsc_pkg::CH_RIGHT_PHOTO];
            r_hi = ch_max_reg[lsc_pkg::CH_RIGHT_PHOTO];
        end
    end

    lsc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lane_start),
        .x       (l_x),
        .lo      (l_lo),
        .hi      (l_hi),
        .res     (lane_l)
    );

    lsc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lane_start),
        .x       (r_x),
        .lo      (r_lo),
        .hi      (r_hi),
        .res     (lane_r)
    );

    lsc_merge u_merge (
        .left_level  (lane_l.level),
        .right_level (lane_r.level),
        .threshold   (thresh_reg),
        .decision    (merged)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = s_cmd ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV: begin
                if (lane_l.done && lane_r.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            thresh_reg  <= lsc_pkg::THRESHOLD_RESET;
            for (int i = 0; i < lsc_pkg::NUM_CH; i++) begin
                ch_min_reg[i] <= '1;
                ch_max_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                thresh_reg <= cfg_wdata;
            end
            if (accept && !s_cmd) begin
                for (int i = 0; i < lsc_pkg::NUM_CH; i++) begin
                    if (samp[i] > ch_max_reg[i]) begin
                        ch_max_reg[i] <= samp[i];
                    end
                    if (samp[i] < ch_min_reg[i]) begin
                        ch_min_reg[i] <= samp[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            is_cal_reg <= !s_cmd;
        end
        if (out_load) begin
            if (is_cal_reg) begin
                m_decision_reg <= lsc_pkg::DEC_KEEP;
                m_left_reg     <= '0;
                m_right_reg    <= '0;
            end else begin
                m_decision_reg <= merged;
                m_left_reg     <= lane_l.level;
                m_right_reg    <= lane_r.level;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_decision    = m_decision_reg;
    assign m_left_level  = m_left_reg;
    assign m_right_level = m_right_reg;

    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_l.done == lane_r.done)
        else $error("divider lanes finished out of step");

    a_done_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_l.done |-> (state_reg == ST_DIV))
        else $error("lane finished outside a check");

    a_cal_orders_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_cmd) |=> (ch_min_reg[0] <= ch_max_reg[0]))
        else $error("calibration left an inverted range");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the emit step");

endmodule
